// ===== rtl/core/qdec_pkg.sv =====
// Shared types and constants for the multi-channel quadrature decoder.
// Self-contained; every other file in rtl/core imports this package.
package qdec_pkg;

  // Number of encoder channels held in the core.
  localparam int NumChan  = 4;
  localparam int PinW     = 4;
  localparam int PosW     = 32;
  localparam int ActW     = 3;
  localparam int ChanIdxW = (NumChan > 1) ? $clog2(NumChan) : 1;
  localparam int CntW     = ($clog2(NumChan + 1) > ActW) ? $clog2(NumChan + 1) : ActW;
  localparam int ExtW     = (NumChan > PinW) ? NumChan : PinW;

  // Queue between the classifier and the execution stage.
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Indexed by {previous AB, new AB}; both lines changing at once gives zero.
  localparam logic signed [1:0] StepTable [16] = '{
    2'sb00, 2'sb11, 2'sb01, 2'sb00,
    2'sb01, 2'sb00, 2'sb00, 2'sb11,
    2'sb11, 2'sb00, 2'sb00, 2'sb01,
    2'sb00, 2'sb01, 2'sb11, 2'sb00
  };

  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqRead  = 2'd1,
    ReqWrite = 2'd2,
    ReqRsvd  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OpTick,
    OpRead,
    OpWrite,
    OpReject,
    OpIgnore
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [ChanIdxW-1:0]       chan;
    logic [NumChan-1:0][1:0]   ab;
    logic [NumChan-1:0]        en;
    logic [PosW-1:0]           wdata;
  } cmd_t;

endpackage

// ===== rtl/core/qdec_front.sv =====
// Request classifier: holds the active channel count and turns each input
// beat into a decoded command. Depends on qdec_pkg.
module qdec_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [qdec_pkg::ActW-1:0] cfg_data_i,
  input  logic [1:0]             req_type_i,
  input  logic [1:0]             channel_i,
  input  logic [3:0]             pins_a_i,
  input  logic [3:0]             pins_b_i,
  input  logic signed [31:0]     write_value_i,
  output qdec_pkg::cmd_t         cmd_o
);
  import qdec_pkg::*;

  logic [ActW-1:0] active_q;
  logic [ActW-1:0] active_d;
  logic [CntW-1:0] num_active;
  logic [ExtW-1:0] pa_ext;
  logic [ExtW-1:0] pb_ext;
  logic            chan_ok;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    active_d = active_q;
    if (cfg_valid_i) begin
      active_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else begin
      active_q <= active_d;
    end
  end

  // Counts above the channel total act as the channel total.
  assign num_active = (CntW'(active_q) > CntW'(NumChan)) ? CntW'(NumChan) : CntW'(active_q);
  assign pa_ext     = ExtW'(pins_a_i);
  assign pb_ext     = ExtW'(pins_b_i);
  assign chan_ok    = CntW'(channel_i) < num_active;

  always_comb begin
    cmd_o.chan  = ChanIdxW'(channel_i);
    cmd_o.wdata = write_value_i;
    for (int i = 0; i < NumChan; i++) begin
      cmd_o.ab[i] = {pb_ext[i], pa_ext[i]};
      cmd_o.en[i] = CntW'(i) < num_active;
    end
    unique case (req_e'(req_type_i))
      ReqTick:  cmd_o.op = OpTick;
      ReqRead:  cmd_o.op = chan_ok ? OpRead : OpReject;
      ReqWrite: cmd_o.op = chan_ok ? OpWrite : OpReject;
      default:  cmd_o.op = OpIgnore;
    endcase
  end

endmodule

// ===== rtl/core/qdec_fifo.sv =====
// Short command queue between the classifier and the execution stage.
// Depends on qdec_pkg for the command type and depth.
module qdec_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qdec_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output qdec_pkg::cmd_t data_o,
  output logic           empty_o
);
  import qdec_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;

  assign full_o  = count_q == FifoCntW'(FifoDepth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

// ===== rtl/core/qdec_back.sv =====
// Execution stage: holds per-channel AB state and positions, applies commands
// and registers the result beat. Depends on qdec_pkg.
module qdec_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  qdec_pkg::cmd_t     cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic               status_o
);
  import qdec_pkg::*;

  logic [NumChan-1:0][PosW-1:0] position_q, position_d;
  logic [NumChan-1:0][1:0]      last_ab_q, last_ab_d;
  logic                         out_valid_q, out_valid_d;
  logic [PosW-1:0]              read_value_q, read_value_d;
  logic                         status_q, status_d;

  // A command executes whenever the result register is free or being drained.
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    logic signed [1:0] step;
    step         = '0;
    position_d   = position_q;
    last_ab_d    = last_ab_q;
    read_value_d = read_value_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (pop_o) begin
      out_valid_d  = 1'b1;
      read_value_d = '0;
      status_d     = 1'b0;
      unique case (cmd_i.op)
        OpTick: begin
          for (int i = 0; i < NumChan; i++) begin
            if (cmd_i.en[i]) begin
              step          = StepTable[{last_ab_q[i], cmd_i.ab[i]}];
              position_d[i] = position_q[i] + PosW'(step);
              last_ab_d[i]  = cmd_i.ab[i];
            end
          end
        end
        OpRead:   read_value_d = position_q[cmd_i.chan];
        OpWrite:  position_d[cmd_i.chan] = cmd_i.wdata;
        OpReject: status_d = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      last_ab_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      position_q  <= position_d;
      last_ab_q   <= last_ab_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_value_q <= read_value_d;
    status_q     <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;

  a_reject_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.op == OpReject |=> out_valid_q && status_q && read_value_q == '0)
    else $error("rejected access not flagged");

  a_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.op == OpTick |=> out_valid_q && !status_q && read_value_q == '0)
    else $error("tick result not zero");

  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.op == OpWrite |=> position_q[$past(cmd_i.chan)] == $past(cmd_i.wdata))
    else $error("position write lost");

endmodule

// ===== rtl/core/multi_channel_quadrature_decoder_core.sv =====
// Multi-channel x4 quadrature decoder, top level. Depends on qdec_pkg.
// An accepted beat is written into the queue and executed from there into the result register.
// Throughput: one beat per cycle while the output side accepts results; the two-entry queue
// plus the result register hold up to three beats while the output side stalls.
// Reset clears the active channel count, all AB states and all positions.
module multi_channel_quadrature_decoder_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [qdec_pkg::ActW-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [1:0]             channel_i,
  input  logic [3:0]             pins_a_i,
  input  logic [3:0]             pins_b_i,
  input  logic signed [31:0]     write_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [31:0]     read_value_o,
  output logic                   status_o
);
  import qdec_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic full;
  logic empty;
  logic pop;

  assign in_ready_o = !full;

  qdec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .channel_i    (channel_i),
    .pins_a_i     (pins_a_i),
    .pins_b_i     (pins_b_i),
    .write_value_i(write_value_i),
    .cmd_o        (front_cmd)
  );

  qdec_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i && !full),
    .data_i (front_cmd),
    .full_o (full),
    .pop_i  (pop),
    .data_o (queue_cmd),
    .empty_o(empty)
  );

  qdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .status_o    (status_o)
  );

endmodule
